// File: design/assert_macros.svh
// Assertion macros included by the core design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/bmsw_pkg.sv
// Types and constants of the binary morphology square window core.
`timescale 1ns / 1ps

package bmsw_pkg;

    localparam int PIX_W      = 8;
    localparam int OUT_ROW_W  = 10;
    localparam int OUT_COL_W  = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_SIZE_W = 11;
    localparam int CFG_RAD_W  = 2;

    localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_RADIUS = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             start_of_frame;
    } pix_t;

    typedef struct packed {
        logic [PIX_W-1:0]     out_pixel;
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic                 end_of_frame;
    } res_t;

endpackage

// File: design/bmsw_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module bmsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/binary_morphology_square_window_core.sv
// Top level: streaming binary erosion/dilation over a square window.
//
//  channel | signals                      | dir | beat
//  pix     | pix_valid, pix_stall, pix    | in  | one mask pixel, raster order
//  res     | res_valid, res_stall, res    | out | one interior result, center coords
//  cfg     | cfg_we, cfg_index, cfg_data  | in  | one register write
//
// One pixel per cycle unless stalled; results go via stage 1 and the output queue.
// The column RAM (one word of 2*MAX_RADIUS+1 row bits per column) is read and written
// once per pixel; back-to-back beats on the same column are forwarded.
// After reset a clearing pass writes zero to every RAM address; pix_stall is high then.
// res_stall backs up into a four-beat output queue, then into pix_stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_morphology_square_window_core
    import bmsw_pkg::*;
#(
    parameter int MAX_RADIUS = 3,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  pix_t                  pix,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_t                  res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RING   = 2 * MAX_RADIUS + 1;
    localparam int RING_W = $clog2(RING);
    localparam int WIN    = 2 * MAX_RADIUS;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int HW     = $clog2(MAX_HEIGHT);
    localparam int CW1    = CW + 1;
    localparam int HW1    = HW + 1;
    localparam int SWW    = (CFG_SIZE_W > CW1) ? CFG_SIZE_W : CW1;
    localparam int SHW    = (CFG_SIZE_W > HW1) ? CFG_SIZE_W : HW1;
    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int RRW    = (CFG_RAD_W > RW) ? CFG_RAD_W : RW;
    localparam int FIFO_DEPTH = 4;
    localparam int FPW    = $clog2(FIFO_DEPTH);

    typedef enum logic {ST_CLEAR, ST_RUN} state_t;

    // configuration
    logic                  mode_reg;
    logic [CFG_RAD_W-1:0]  radius_reg;
    logic [CFG_SIZE_W-1:0] width_reg;
    logic [CFG_SIZE_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            radius_reg <= 2'd2;
            width_reg  <= 11'd640;
            height_reg <= 11'd480;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_RADIUS: radius_reg <= cfg_data[CFG_RAD_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data[CFG_SIZE_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[CFG_SIZE_W-1:0];
                default:    ;
            endcase
        end
    end

    // effective sizes
    logic [SWW-1:0]    width_ext;
    logic [SHW-1:0]    height_ext;
    logic [RRW-1:0]    radius_ext;
    logic [CW1-1:0]    w_eff;
    logic [HW1-1:0]    h_eff;
    logic [RW-1:0]     r_eff;
    logic [RING_W-1:0] two_r;

    always_comb
    begin
        width_ext  = SWW'(width_reg);
        height_ext = SHW'(height_reg);
        radius_ext = RRW'(radius_reg);
        if (width_ext == '0)
            w_eff = CW1'(1);
        else if (width_ext > SWW'(MAX_WIDTH))
            w_eff = CW1'(MAX_WIDTH);
        else
            w_eff = CW1'(width_ext);
        if (height_ext == '0)
            h_eff = HW1'(1);
        else if (height_ext > SHW'(MAX_HEIGHT))
            h_eff = HW1'(MAX_HEIGHT);
        else
            h_eff = HW1'(height_ext);
        if (radius_ext > RRW'(MAX_RADIUS))
            r_eff = RW'(MAX_RADIUS);
        else
            r_eff = RW'(radius_ext);
        two_r = RING_W'({r_eff, 1'b0});
    end

    // clearing pass and pipeline control
    state_t         state_reg;
    logic [CW-1:0]  clr_addr_reg;
    logic           s1_valid_reg;
    logic [FPW:0]   cnt_reg;
    logic           accept;

    assign pix_stall = (state_reg == ST_CLEAR) ||
                       ((cnt_reg + (FPW+1)'(s1_valid_reg)) >= (FPW+1)'(FIFO_DEPTH));
    assign accept    = pix_valid && !pix_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + CW'(1);
                    if (clr_addr_reg == CW'(MAX_WIDTH - 1))
                        state_reg <= ST_RUN;
                end
                ST_RUN:  ;
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    // position of the incoming pixel
    logic [CW-1:0]     col_cnt_reg;
    logic [HW-1:0]     row_cnt_reg;
    logic [RING_W-1:0] ring_reg;

    logic [CW1-1:0]    c1, cn;
    logic [HW1-1:0]    r1, rn;
    logic [RING_W-1:0] g1, gn;
    logic [CW-1:0]     cur_col;
    logic [HW-1:0]     cur_row;
    logic              cur_emit;
    logic              cur_eof;
    logic [RING-1:0]   cur_rowmask;
    logic [RING_W:0]   dsum;

    always_comb
    begin
        if (pix.start_of_frame)
        begin
            c1 = '0;
            r1 = '0;
            g1 = '0;
        end
        else
        begin
            c1 = CW1'(col_cnt_reg);
            r1 = HW1'(row_cnt_reg);
            g1 = ring_reg;
        end
        if (c1 >= w_eff)
        begin
            c1 = '0;
            r1 = r1 + HW1'(1);
            g1 = (g1 == RING_W'(RING - 1)) ? '0 : g1 + RING_W'(1);
        end
        if (r1 >= h_eff)
        begin
            r1 = '0;
            g1 = '0;
        end
        cur_col = c1[CW-1:0];
        cur_row = r1[HW-1:0];

        cn = c1 + CW1'(1);
        rn = r1;
        gn = g1;
        if (cn >= w_eff)
        begin
            cn = '0;
            rn = r1 + HW1'(1);
            gn = (g1 == RING_W'(RING - 1)) ? '0 : g1 + RING_W'(1);
            if (rn >= h_eff)
            begin
                rn = '0;
                gn = '0;
            end
        end

        cur_emit = (r1 >= HW1'(two_r)) && (c1 >= CW1'(two_r));
        cur_eof  = (r1 == h_eff - HW1'(1)) && (c1 == w_eff - CW1'(1));

        for (int i = 0; i < RING; i++)
        begin
            dsum = {1'b0, g1} + (RING_W+1)'(RING) - (RING_W+1)'(i);
            if (dsum >= (RING_W+1)'(RING))
                dsum = dsum - (RING_W+1)'(RING);
            cur_rowmask[i] = (dsum <= {1'b0, two_r});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            ring_reg    <= '0;
        end
        else if (accept)
        begin
            col_cnt_reg <= cn[CW-1:0];
            row_cnt_reg <= rn[HW-1:0];
            ring_reg    <= gn;
        end
    end

    // stage 1: column word read back, merged, written, window evaluated
    logic [RING_W-1:0]    s1_ring_reg;
    logic                 s1_bit_reg;
    logic [CW-1:0]        s1_col_reg;
    logic                 s1_emit_reg;
    logic                 s1_eof_reg;
    logic                 s1_mode_reg;
    logic [RING_W-1:0]    s1_two_r_reg;
    logic [RING-1:0]      s1_rowmask_reg;
    logic [OUT_ROW_W-1:0] s1_out_row_reg;
    logic [OUT_COL_W-1:0] s1_out_col_reg;
    logic                 s1_fwd_reg;
    logic [RING-1:0]      last_word_reg;
    logic [RING-1:0]      win_reg [WIN];

    logic [RING-1:0]      rd_word;
    logic [RING-1:0]      base_word;
    logic [RING-1:0]      merged;
    logic                 win_all;
    logic                 win_any;
    logic [RING-1:0]      col_word;
    logic                 col_on;
    logic                 ram_we;
    logic [CW-1:0]        ram_waddr;
    logic [RING-1:0]      ram_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
                s1_fwd_reg <= s1_valid_reg && (s1_col_reg == cur_col);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ring_reg    <= g1;
            s1_bit_reg     <= (pix.pixel_value != '0);
            s1_col_reg     <= cur_col;
            s1_emit_reg    <= cur_emit;
            s1_eof_reg     <= cur_eof;
            s1_mode_reg    <= mode_reg;
            s1_two_r_reg   <= two_r;
            s1_rowmask_reg <= cur_rowmask;
            s1_out_row_reg <= OUT_ROW_W'(cur_row - HW'(r_eff));
            s1_out_col_reg <= OUT_COL_W'(cur_col - CW'(r_eff));
        end
        if (s1_valid_reg)
        begin
            last_word_reg <= merged;
            win_reg[0]    <= merged;
            for (int j = 1; j < WIN; j++)
                win_reg[j] <= win_reg[j-1];
        end
    end

    always_comb
    begin
        base_word = s1_fwd_reg ? last_word_reg : rd_word;
        for (int i = 0; i < RING; i++)
            merged[i] = (RING_W'(i) == s1_ring_reg) ? s1_bit_reg : base_word[i];

        win_all = 1'b1;
        win_any = 1'b0;
        for (int j = 0; j <= WIN; j++)
        begin
            col_word = (j == 0) ? merged : win_reg[(j == 0) ? 0 : j - 1];
            col_on   = (RING_W'(j) <= s1_two_r_reg);
            win_all  = win_all & (!col_on | (&(col_word | ~s1_rowmask_reg)));
            win_any  = win_any | (col_on & (|(col_word & s1_rowmask_reg)));
        end

        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_valid_reg;
            ram_waddr = s1_col_reg;
            ram_wdata = merged;
        end
    end

    bmsw_ram #(
        .WIDTH (RING),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (cur_col),
        .rdata (rd_word)
    );

    // output queue
    res_t           fifo_mem [FIFO_DEPTH];
    logic [FPW-1:0] wr_ptr_reg;
    logic [FPW-1:0] rd_ptr_reg;
    logic           push;
    logic           pop;
    res_t           push_res;

    assign push = s1_valid_reg && s1_emit_reg;
    assign pop  = res_valid && !res_stall;

    always_comb
    begin
        push_res.out_pixel    = (s1_mode_reg ? win_any : win_all) ? PIX_ON : PIX_OFF;
        push_res.out_row      = s1_out_row_reg;
        push_res.out_col      = s1_out_col_reg;
        push_res.end_of_frame = s1_eof_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FPW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FPW'(1);
            cnt_reg <= cnt_reg + (FPW+1)'(push) - (FPW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= push_res;
    end

    assign res_valid = (cnt_reg != '0);
    assign res       = fifo_mem[rd_ptr_reg];

    `ASSERT_NEVER(a_fifo_overflow, push && !pop && (cnt_reg == (FPW+1)'(FIFO_DEPTH)), "output queue overflow")
    `ASSERT_CLK(a_no_pixel_during_clear, (state_reg == ST_CLEAR) |-> !s1_valid_reg, "pixel in flight during clearing pass")
    `ASSERT_CLK(a_fwd_needs_prev, s1_fwd_reg && s1_valid_reg |-> $past(s1_valid_reg), "forward without a preceding write")

endmodule

// File: tb/binary_morphology_square_window_core_test.sv
// Self-checking testbench: directed and random mask streams checked against a window predictor.
`timescale 1ns / 1ps
module binary_morphology_square_window_core_test;
    import bmsw_pkg::*;

    localparam int unsigned RADIUS_LIM = 3;
    localparam int unsigned WIDTH_LIM  = 1024;
    localparam int unsigned HEIGHT_LIM = 1024;
    localparam int unsigned RING       = 2 * RADIUS_LIM + 1;
    localparam int          SETTLE     = 8;
    localparam int          RANDOM_ITEMS = 450;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pix_valid;
    logic                  pix_stall;
    pix_t                  pix;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    res_t                  res;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    binary_morphology_square_window_core #(
        .MAX_RADIUS(RADIUS_LIM),
        .MAX_WIDTH (WIDTH_LIM),
        .MAX_HEIGHT(HEIGHT_LIM)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix      (pix),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // predictor state
    bit                    fg_rows [RING][WIDTH_LIM];
    int unsigned           col_cnt = 0;
    int unsigned           row_cnt = 0;
    logic                  cur_mode = 1'b0;
    logic [CFG_RAD_W-1:0]  cur_radius = 2'd2;
    logic [CFG_SIZE_W-1:0] cur_width = 11'd640;
    logic [CFG_SIZE_W-1:0] cur_height = 11'd480;

    res_t pending_results [$];
    int   mismatches = 0;
    int   beats_sent = 0;
    int   results_seen = 0;
    int   results_set = 0;
    int   settings_run = 0;
    int   stall_left = 0;
    bit   tx_calm = 1'b0;
    bit   rx_calm = 1'b0;

    typedef struct {
        int is_cfg, mode, rad, wid, hgt, val, sof, typed, opix, orow, ocol, eof;
    } step_row_t;

    // cfg rows: mode, radius, width, height; pixel rows: value, sof, typed result
    step_row_t script [22] = '{
        '{1, 0, 0, 3, 2,   0, 0, 0,   0, 0, 0, 0},
        '{0, 0, 0, 0, 0,   0, 1, 1,   0, 0, 0, 0},
        '{0, 0, 0, 0, 0,   1, 0, 1, 255, 0, 1, 0},
        '{0, 0, 0, 0, 0, 255, 0, 1, 255, 0, 2, 0},
        '{0, 0, 0, 0, 0, 128, 0, 1, 255, 1, 0, 0},
        '{0, 0, 0, 0, 0,   0, 0, 1,   0, 1, 1, 0},
        '{0, 0, 0, 0, 0, 127, 0, 1, 255, 1, 2, 1},
        '{0, 0, 0, 0, 0, 255, 0, 1, 255, 0, 0, 0},
        '{0, 0, 0, 0, 0,   0, 1, 1,   0, 0, 0, 0},
        '{1, 1, 0, 0, 0,   0, 0, 0,   0, 0, 0, 0},
        '{0, 0, 0, 0, 0,  85, 0, 1, 255, 0, 0, 1},
        '{0, 0, 0, 0, 0,   0, 0, 1,   0, 0, 0, 1},
        '{1, 1, 1, 3, 3,   0, 0, 0,   0, 0, 0, 0},
        '{0, 0, 0, 0, 0,   0, 1, 0,   0, 0, 0, 0},
        '{0, 0, 0, 0, 0,   0, 0, 0,   0, 0, 0, 0},
        '{0, 0, 0, 0, 0,   0, 0, 0,   0, 0, 0, 0},
        '{0, 0, 0, 0, 0,   0, 0, 0,   0, 0, 0, 0},
        '{0, 0, 0, 0, 0,   0, 0, 0,   0, 0, 0, 0},
        '{0, 0, 0, 0, 0,   0, 0, 0,   0, 0, 0, 0},
        '{0, 0, 0, 0, 0,   0, 0, 0,   0, 0, 0, 0},
        '{0, 0, 0, 0, 0,   0, 0, 0,   0, 0, 0, 0},
        '{0, 0, 0, 0, 0,   1, 0, 1, 255, 1, 1, 1}
    };

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout: %0d results still pending", pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned clamp_size(input logic [CFG_SIZE_W-1:0] v,
                                               input int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    // advances the window state by one pixel; returns 1 when a center result is due
    function automatic bit morph_predict(input pix_t p, output res_t r);
        int unsigned w, h, rad, row, col, i, k;
        bit all_set, any_set, hit;
        w = clamp_size(cur_width, WIDTH_LIM);
        h = clamp_size(cur_height, HEIGHT_LIM);
        rad = (cur_radius > RADIUS_LIM) ? RADIUS_LIM : cur_radius;
        r = '0;
        morph_predict = 1'b0;
        if (p.start_of_frame)
        begin
            row_cnt = 0;
            col_cnt = 0;
        end
        if (col_cnt >= w)
        begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h)
            row_cnt = 0;
        row = row_cnt;
        col = col_cnt;
        fg_rows[row % RING][col] = (p.pixel_value != 0);
        if (row >= 2 * rad && col >= 2 * rad)
        begin
            all_set = 1'b1;
            any_set = 1'b0;
            for (i = row - 2 * rad; i <= row; i++)
                for (k = col - 2 * rad; k <= col; k++)
                    if (fg_rows[i % RING][k])
                        any_set = 1'b1;
                    else
                        all_set = 1'b0;
            hit = cur_mode ? any_set : all_set;
            r.out_pixel = hit ? PIX_ON : PIX_OFF;
            r.out_row = OUT_ROW_W'(row - rad);
            r.out_col = OUT_COL_W'(col - rad);
            r.end_of_frame = (row == h - 1 && col == w - 1);
            morph_predict = 1'b1;
        end
        col_cnt = col + 1;
        if (col_cnt >= w)
        begin
            col_cnt = 0;
            row_cnt = row + 1;
            if (row_cnt >= h)
                row_cnt = 0;
        end
    endfunction

    task automatic send_pixel(input pix_t p, input bit typed, input res_t want);
        int   gap;
        bit   due;
        res_t r;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix <= p;
        pix_valid <= 1'b1;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        due = morph_predict(p, r);
        if (typed)
            pending_results.push_back(want);
        else if (due)
            pending_results.push_back(r);
        beats_sent++;
    endtask

    // waits out every pending result plus the pipeline tail
    task automatic drain();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        case (idx)
            CFG_MODE:   cur_mode = d[0];
            CFG_RADIUS: cur_radius = d[CFG_RAD_W-1:0];
            CFG_WIDTH:  cur_width = d;
            CFG_HEIGHT: cur_height = d;
            default:    ;
        endcase
    endtask

    task automatic write_regs(input int m, input int rd, input int w, input int h);
        put_reg(CFG_MODE, CFG_DATA_W'(m));
        put_reg(CFG_RADIUS, CFG_DATA_W'(rd));
        put_reg(CFG_WIDTH, CFG_DATA_W'(w));
        put_reg(CFG_HEIGHT, CFG_DATA_W'(h));
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    function automatic int draw_size();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return 1;
            2:       return 1024;
            3:       return $urandom_range(1025, 2047);
            default: return $urandom_range(2, 12);
        endcase
    endfunction

    task automatic run_phase(input int m, input int rd, input int w, input int h,
                             input int count, input bit noisy);
        int   area, dens, i;
        bit   fg;
        pix_t p;
        drain();
        write_regs(m, rd, w, h);
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        dens = $urandom_range(0, 3);
        area = clamp_size(CFG_SIZE_W'(w), WIDTH_LIM) * clamp_size(CFG_SIZE_W'(h), HEIGHT_LIM);
        for (i = 0; i < count; i++)
        begin
            case (dens)
                0:       fg = ($urandom_range(0, 15) == 0);
                1:       fg = 1'b1;
                2:       fg = 1'($urandom_range(0, 1));
                default: fg = ($urandom_range(0, 15) != 0);
            endcase
            p.pixel_value = fg ? PIX_W'($urandom_range(1, 255)) : PIX_OFF;
            if (noisy)
                p.start_of_frame = ((i % area == 0) && $urandom_range(0, 3) != 0)
                                   || ($urandom_range(0, 39) == 0);
            else
                p.start_of_frame = (i % area == 0);
            if (noisy && $urandom_range(0, 79) == 0)
                drain();
            send_pixel(p, 1'b0, '0);
        end
    endtask

    // result side: random stall after each beat, compare with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (res.out_pixel == PIX_ON)
                    results_set++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result pix %0d row %0d col %0d eof %0d",
                                 $realtime, res.out_pixel, res.out_row, res.out_col,
                                 res.end_of_frame);
                end
                else
                begin
                    res_t want;
                    want = pending_results.pop_front();
                    if (want.out_pixel !== res.out_pixel || want.out_row !== res.out_row
                        || want.out_col !== res.out_col
                        || want.end_of_frame !== res.end_of_frame)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch: expected pix %0d row %0d col %0d eof %0d,",
                                      " got pix %0d row %0d col %0d eof %0d"},
                                     $realtime, want.out_pixel, want.out_row, want.out_col,
                                     want.end_of_frame, res.out_pixel, res.out_row,
                                     res.out_col, res.end_of_frame);
                    end
                end
                stall_left = rx_calm ? 0 : $urandom_range(0, 13);
            end
            if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
                res_stall <= 1'b0;
        end
    end

    initial
    begin
        int   random_items, m, rd, w, h, count;
        pix_t p;
        res_t want;
        pix_valid <= 1'b0;
        pix <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_MODE;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);

        foreach (script[j])
        begin
            if (script[j].is_cfg != 0)
            begin
                drain();
                write_regs(script[j].mode, script[j].rad, script[j].wid, script[j].hgt);
            end
            else
            begin
                p.pixel_value = PIX_W'(script[j].val);
                p.start_of_frame = script[j].sof[0];
                want.out_pixel = PIX_W'(script[j].opix);
                want.out_row = OUT_ROW_W'(script[j].orow);
                want.out_col = OUT_COL_W'(script[j].ocol);
                want.end_of_frame = script[j].eof[0];
                send_pixel(p, script[j].typed[0], want);
            end
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            m = $urandom_range(0, 1);
            rd = $urandom_range(0, 3);
            w = draw_size();
            h = draw_size();
            count = clamp_size(CFG_SIZE_W'(w), WIDTH_LIM) * clamp_size(CFG_SIZE_W'(h), HEIGHT_LIM)
                    * $urandom_range(1, 3);
            if (count > 150)
                count = $urandom_range(40, 150);
            run_phase(m, rd, w, h, count, 1'b1);
            random_items += count;
        end

        // widest row through its saturation, past the row wrap
        run_phase(1, 0, 2047, 1, 1025, 1'b0);

        drain();
        $display("Sent %0d pixel beats under %0d register settings (erosion and dilation, r 0..3)",
                 beats_sent, settings_run);
        $display("Checked %0d results, %0d set; %0d mismatches",
                 results_seen, results_set, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/bmsw_pkg.sv
design/bmsw_ram.sv
design/binary_morphology_square_window_core.sv
tb/binary_morphology_square_window_core_test.sv
